@@ hw/rtl/mfd_pkg.sv @@
// Shared constants, types and helpers for the modem frame deframer.
package mfd_pkg;

  localparam logic [7:0] StartByte   = 8'hD0;
  localparam logic [7:0] TypeMask    = 8'h7F;
  localparam logic [7:0] LimitReset  = 8'd100;
  localparam logic [8:0] HeaderLast  = 9'd4;
  localparam logic [7:0] BitTxEn     = 8'h02;
  localparam logic [7:0] BitCksum    = 8'h08;

  localparam logic [8:0] PosLenLow   = 9'd1;
  localparam logic [8:0] PosLenHigh  = 9'd2;
  localparam logic [8:0] PosType     = 9'd3;
  localparam logic [8:0] PosStatA    = 9'd4;
  localparam logic [8:0] PosStatB    = 9'd5;
  localparam logic [8:0] PosSpace    = 9'd8;
  localparam logic [8:0] PosUsed     = 9'd9;

  localparam logic [7:0] TypeFirst   = 8'h10;
  localparam logic [7:0] TypeLast    = 8'h1B;
  localparam logic [7:0] TypeTest    = 8'h1F;
  localparam logic [3:0] KindStatus  = 4'd0;
  localparam logic [3:0] KindTest    = 4'd12;
  localparam logic [3:0] KindUnknown = 4'd13;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       frame_end;
    logic       frame_error;
    logic [3:0] frame_kind;
    logic [8:0] frame_length;
    logic       tx_enabled;
    logic       checksum_on;
    logic       transmitting;
    logic [7:0] tx_space;
    logic [7:0] tx_free;
  } result_t;

  function automatic logic [3:0] dense_kind(input logic [7:0] type_byte);
    logic [7:0] t;
    logic [7:0] off;
    t   = type_byte & TypeMask;
    off = t - TypeFirst;
    if (t >= TypeFirst && t <= TypeLast) begin
      dense_kind = off[3:0];
    end else if (t == TypeTest) begin
      dense_kind = KindTest;
    end else begin
      dense_kind = KindUnknown;
    end
  endfunction

endpackage

@@ hw/rtl/mfd_parser.sv @@
// Frame parser: phase tracking, header decode, status capture and result build.
module mfd_parser import mfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] limit_i,
  output logic       emit_o,
  output result_t    res_o
);

  phase_e     phase_q, phase_d;
  logic [8:0] pos_q, pos_d;
  logic [7:0] len_low_q, len_low_d;
  logic       len_big_q, len_big_d;
  logic [7:0] left_q, left_d;
  logic [3:0] kind_q, kind_d;
  logic [7:0] cap_q [4];
  logic [7:0] cap_d [4];

  always_comb begin
    logic finish;
    logic [8:0] pos_inc;
    finish   = 1'b0;
    pos_inc  = pos_q + 9'd1;
    phase_d  = phase_q;
    pos_d    = pos_q;
    len_low_d = len_low_q;
    len_big_d = len_big_q;
    left_d   = left_q;
    kind_d   = kind_q;
    for (int i = 0; i < 4; i++) begin
      cap_d[i] = cap_q[i];
    end
    emit_o = 1'b0;
    res_o  = '0;
    res_o.frame_byte = byte_i;

    case (phase_q)
      PH_HUNT: begin
        if (byte_i == StartByte) begin
          emit_o    = 1'b1;
          phase_d   = PH_HEADER;
          pos_d     = '0;
          len_low_d = '0;
          len_big_d = 1'b0;
          left_d    = '0;
          kind_d    = KindStatus;
          for (int i = 0; i < 4; i++) begin
            cap_d[i] = '0;
          end
        end
      end
      PH_HEADER, PH_PAYLOAD: begin
        emit_o = 1'b1;
        pos_d  = pos_inc;
        res_o.byte_index = pos_inc;
        if (pos_inc == PosStatA) cap_d[0] = byte_i;
        if (pos_inc == PosStatB) cap_d[1] = byte_i;
        if (pos_inc == PosSpace) cap_d[2] = byte_i;
        if (pos_inc == PosUsed)  cap_d[3] = byte_i;
        if (phase_q == PH_HEADER) begin
          if (pos_inc == PosLenLow) begin
            len_low_d = byte_i;
          end else if (pos_inc == PosLenHigh) begin
            len_big_d = (byte_i != 8'd0);
          end else if (pos_inc == PosType) begin
            kind_d = dense_kind(byte_i);
          end else begin
            left_d = len_low_q;
            if (len_big_q || len_low_q >= limit_i) begin
              res_o.frame_end   = 1'b1;
              res_o.frame_error = 1'b1;
              phase_d = PH_HUNT;
            end else if (len_low_q == 8'd0) begin
              finish = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end else begin
          if (left_q != 8'd0) left_d = left_q - 8'd1;
          if (left_q <= 8'd1) finish = 1'b1;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase

    if (finish) begin
      phase_d = PH_HUNT;
      res_o.frame_end    = 1'b1;
      res_o.frame_kind   = kind_q;
      res_o.frame_length = pos_inc + 9'd1;
      if (kind_q == KindStatus) begin
        res_o.tx_enabled   = (cap_d[0] & BitTxEn) != 8'd0;
        res_o.checksum_on  = (cap_d[0] & BitCksum) != 8'd0;
        res_o.transmitting = (cap_d[1] & BitTxEn) != 8'd0;
        res_o.tx_space     = cap_d[2];
        res_o.tx_free      = (cap_d[2] > cap_d[3]) ? (cap_d[2] - cap_d[3]) : 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      pos_q     <= '0;
      len_low_q <= '0;
      len_big_q <= 1'b0;
      left_q    <= '0;
      kind_q    <= KindStatus;
      for (int i = 0; i < 4; i++) begin
        cap_q[i] <= '0;
      end
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      len_low_q <= len_low_d;
      len_big_q <= len_big_d;
      left_q    <= left_d;
      kind_q    <= kind_d;
      for (int i = 0; i < 4; i++) begin
        cap_q[i] <= cap_d[i];
      end
    end
  end

endmodule

@@ hw/rtl/modem_frame_deframer.sv @@
// Top level of the modem frame deframer: input register, parser, result register.
// Takes one received byte per cycle unless out_stall_i holds the result register;
// each byte passes the input register, then the parser logic, then the result
// register. Bytes dropped while hunting for the start byte give no result. The
// length limit register (cfg_wr_en_i/cfg_wr_data_i, resets to 100) must be written
// by the user only while the block is idle; the block does not enforce this.
module modem_frame_deframer import mfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic [7:0] cfg_wr_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic [8:0] byte_index_o,
  output logic       frame_end_o,
  output logic       frame_error_o,
  output logic [3:0] frame_kind_o,
  output logic [8:0] frame_length_o,
  output logic       tx_enabled_o,
  output logic       checksum_on_o,
  output logic       transmitting_o,
  output logic [7:0] tx_space_o,
  output logic [7:0] tx_free_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_q;
  logic [7:0] limit_q;
  logic       out_free;
  logic       advance;
  logic       emit;
  result_t    res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  mfd_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .limit_i (limit_q),
    .emit_o  (emit),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_wr_en_i) begin
      limit_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = out_q.frame_byte;
  assign byte_index_o   = out_q.byte_index;
  assign frame_end_o    = out_q.frame_end;
  assign frame_error_o  = out_q.frame_error;
  assign frame_kind_o   = out_q.frame_kind;
  assign frame_length_o = out_q.frame_length;
  assign tx_enabled_o   = out_q.tx_enabled;
  assign checksum_on_o  = out_q.checksum_on;
  assign transmitting_o = out_q.transmitting;
  assign tx_space_o     = out_q.tx_space;
  assign tx_free_o      = out_q.tx_free;

endmodule
